/* design/backslash_newline_line_splicer_unit_assert.svh */
// Assertion macros for the line splicer unit.
// Expects clk and rst in the scope where a macro is used.
`ifndef BACKSLASH_NEWLINE_LINE_SPLICER_UNIT_ASSERT_SVH
`define BACKSLASH_NEWLINE_LINE_SPLICER_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BNLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define BNLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bnls_pkg.sv */
// Shared types and constants for the line splicer unit.
// No dependencies; used by every module of the block.
`default_nettype none

package bnls_pkg;

  localparam int LINE_BITS_DEF = 24;
  localparam int COL_BITS_DEF  = 16;
  localparam int CMD_DEPTH     = 2;
  localparam int RES_DEPTH     = 4;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] NEWLINE   = 8'h0A;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NO_FINAL_NL = 2'd1,
    ERR_SPLICE_EOF  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_SPLICE = 2'd2
  } cmd_kind_t;

  // One classified input byte, handed from front to back.
  typedef struct packed {
    logic      emit_bs;
    cmd_kind_t kind;
    logic [7:0] data;
    logic      fin;
  } cmd_t;

endpackage

`default_nettype wire

/* design/bnls_front.sv */
// Front end: accepts source bytes and resolves held backslashes.
// Depends on bnls_pkg for cmd_t and the character constants.
`default_nettype none

module bnls_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire logic [7:0]     src_byte,
  input  wire logic           final_byte,
  input  wire logic           q_full,
  output bnls_pkg::cmd_t      q_cmd,
  output logic                q_push,
  output logic                held
);

  logic accept;
  logic held_next;

  assign accept = push && !q_full;

  always_comb begin
    q_cmd = '{emit_bs: 1'b0, kind: bnls_pkg::CMD_NONE, data: src_byte, fin: final_byte};
    held_next = held;
    if (held && src_byte == bnls_pkg::NEWLINE) begin
      q_cmd.kind = bnls_pkg::CMD_SPLICE;
      held_next  = 1'b0;
    end else begin
      q_cmd.emit_bs = held;
      // hold a backslash unless nothing can follow it
      if (src_byte == bnls_pkg::BACKSLASH && !final_byte) begin
        q_cmd.kind = bnls_pkg::CMD_NONE;
        held_next  = 1'b1;
      end else begin
        q_cmd.kind = bnls_pkg::CMD_BYTE;
        held_next  = 1'b0;
      end
    end
  end

  // drop transactions that neither emit nor move a counter
  assign q_push = accept && (q_cmd.kind != bnls_pkg::CMD_NONE || q_cmd.emit_bs);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

/* design/bnls_cmd_fifo.sv */
// Short command queue between the front and back ends.
// Depends on bnls_pkg for cmd_t.
`default_nettype none

module bnls_cmd_fifo #(
  parameter int DEPTH = bnls_pkg::CMD_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bnls_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output bnls_pkg::cmd_t      dout,
  output logic                valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bnls_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/bnls_back.sv */
// Back end: runs the line and column counters and builds result items.
// Depends on bnls_pkg for cmd_t, error codes and character constants.
`default_nettype none

module bnls_back #(
  parameter int LINE_BITS = bnls_pkg::LINE_BITS_DEF,
  parameter int COL_BITS  = bnls_pkg::COL_BITS_DEF,
  parameter int RW        = 2 * LINE_BITS + COL_BITS + 13
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire bnls_pkg::cmd_t cmd,
  input  wire logic           room,
  output logic                cmd_pop,
  output logic                res_push0,
  output logic                res_push1,
  output logic [RW-1:0]       res0,
  output logic [RW-1:0]       res1
);

  logic [LINE_BITS-1:0] line;
  logic [LINE_BITS-1:0] line_next;
  logic [COL_BITS-1:0]  col;
  logic [COL_BITS-1:0]  col_next;
  logic [LINE_BITS-1:0] logic_ln;
  logic [LINE_BITS-1:0] logic_ln_next;

  logic [COL_BITS-1:0]  col_a;
  logic [COL_BITS-1:0]  col_b;
  logic [COL_BITS-1:0]  col_c;
  logic [LINE_BITS-1:0] line_inc;
  logic [LINE_BITS-1:0] logic_inc;
  logic                 is_nl;
  logic                 main_valid;
  bnls_pkg::err_t       byte_err;
  logic [RW-1:0]        bs_res;
  logic [RW-1:0]        byte_res;
  logic [RW-1:0]        splice_res;
  logic [RW-1:0]        main_res;

  assign cmd_pop = cmd_valid && room;

  // saturating increments; the byte after an emitted backslash sits one column on
  assign col_a     = (col == {COL_BITS{1'b1}}) ? col : col + COL_BITS'(1);
  assign col_b     = cmd.emit_bs ? col_a : col;
  assign col_c     = (col_b == {COL_BITS{1'b1}}) ? col_b : col_b + COL_BITS'(1);
  assign line_inc  = (line == {LINE_BITS{1'b1}}) ? line : line + LINE_BITS'(1);
  assign logic_inc = (logic_ln == {LINE_BITS{1'b1}}) ? logic_ln : logic_ln + LINE_BITS'(1);

  assign is_nl    = (cmd.data == bnls_pkg::NEWLINE);
  assign byte_err = (cmd.fin && !is_nl) ? bnls_pkg::ERR_NO_FINAL_NL : bnls_pkg::ERR_NONE;

  assign bs_res = {1'b1, bnls_pkg::BACKSLASH, 1'b0, line, col, {LINE_BITS{1'b0}},
                   bnls_pkg::ERR_NONE, 1'b0};
  assign byte_res = {1'b1, cmd.data, is_nl, line, col_b,
                     (is_nl ? logic_ln : {LINE_BITS{1'b0}}), byte_err, cmd.fin};
  assign splice_res = {1'b0, 8'h00, 1'b0, line, col, {LINE_BITS{1'b0}},
                       bnls_pkg::ERR_SPLICE_EOF, 1'b1};

  assign main_valid = (cmd.kind == bnls_pkg::CMD_BYTE) ||
                      (cmd.kind == bnls_pkg::CMD_SPLICE && cmd.fin);
  assign main_res   = (cmd.kind == bnls_pkg::CMD_SPLICE) ? splice_res : byte_res;

  always_comb begin
    if (cmd.emit_bs) begin
      res0      = bs_res;
      res1      = main_res;
      res_push0 = cmd_pop;
      res_push1 = cmd_pop && main_valid;
    end else begin
      res0      = main_res;
      res1      = main_res;
      res_push0 = cmd_pop && main_valid;
      res_push1 = 1'b0;
    end
  end

  always_comb begin
    line_next     = line;
    col_next      = col;
    logic_ln_next = logic_ln;
    case (cmd.kind)
      bnls_pkg::CMD_BYTE: begin
        if (is_nl) begin
          line_next     = line_inc;
          col_next      = COL_BITS'(1);
          logic_ln_next = logic_inc;
        end else begin
          col_next = col_c;
        end
      end
      bnls_pkg::CMD_SPLICE: begin
        line_next = line_inc;
        col_next  = COL_BITS'(1);
      end
      default: begin
        col_next = col_b;
      end
    endcase
    // a new file starts after the final byte
    if (cmd.fin) begin
      line_next     = LINE_BITS'(1);
      col_next      = COL_BITS'(1);
      logic_ln_next = LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line     <= LINE_BITS'(1);
      col      <= COL_BITS'(1);
      logic_ln <= LINE_BITS'(1);
    end else if (cmd_pop) begin
      line     <= line_next;
      col      <= col_next;
      logic_ln <= logic_ln_next;
    end
  end

endmodule

`default_nettype wire

/* design/bnls_res_fifo.sv */
// Result queue with two write ports and one read port.
// Depends on bnls_pkg for the default depth.
`default_nettype none

module bnls_res_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = bnls_pkg::RES_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push0,
  input  wire logic          push1,
  input  wire logic [W-1:0]  d0,
  input  wire logic [W-1:0]  d1,
  output logic               room,
  input  wire logic          pop,
  output logic [W-1:0]       dout,
  output logic               empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] wp1;
  logic [PW-1:0] wp2;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;

  assign wp1   = (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign wp2   = (wp1 == PW'(DEPTH - 1)) ? '0 : wp1 + 1'b1;
  assign empty = (count == '0);
  assign room  = (count <= CW'(DEPTH - 2));
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wp] <= d0;
    end
    if (push1) begin
      mem[wp1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push1) begin
        wp <= wp2;
      end else if (push0) begin
        wp <= wp1;
      end
      if (pop && !empty) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CW'(push0) + CW'(push1) - CW'(pop && !empty);
    end
  end

endmodule

`default_nettype wire

/* design/backslash_newline_line_splicer_unit.sv */
// Backslash-newline line splicer: source bytes in, spliced bytes with
// physical line, column and logical line out, plus end-of-file errors.
//
// Input channel: present src_byte and final_byte with push high; a transaction
// completes on a rising edge with push high and full low. One byte per cycle
// is taken as long as full stays low.
// Result channel: while empty is low the oldest result sits on the output
// ports; pop high at a rising edge takes it. A byte yields zero, one or two
// results (a held backslash plus the byte that follows it).
// Taken bytes are registered in the command queue, results in the result
// queue. The back end writes up to two results per cycle into a four-entry
// result queue and runs one command per cycle while that queue has two free
// entries, so the sustained rate is one byte per cycle, limited to one result
// per cycle by the read port when many backslashes are emitted.
// When pop stays low, the result queue runs short of two free entries, the
// back end stops, the two-entry command queue fills and full rises.
// Reset (rst, synchronous) empties both queues, drops a held backslash and
// sets all line and column counters to 1; after final_byte the hold and counters clear too.
// Depends on bnls_pkg, bnls_front, bnls_cmd_fifo, bnls_back, bnls_res_fifo.
`default_nettype none

`include "backslash_newline_line_splicer_unit_assert.svh"

module backslash_newline_line_splicer_unit #(
  parameter int LINE_BITS = bnls_pkg::LINE_BITS_DEF,
  parameter int COL_BITS  = bnls_pkg::COL_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [7:0]           src_byte,
  input  wire logic                 final_byte,
  input  wire logic                 pop,
  output logic                      empty,
  output logic                      has_char,
  output logic [7:0]                char_out,
  output logic                      is_newline,
  output logic [LINE_BITS-1:0]      phys_line_out,
  output logic [COL_BITS-1:0]       column_out,
  output logic [LINE_BITS-1:0]      logic_line_out,
  output logic [1:0]                error_code,
  output logic                      end_mark
);

  localparam int RW = 2 * LINE_BITS + COL_BITS + 13;

  bnls_pkg::cmd_t fe_cmd;
  bnls_pkg::cmd_t be_cmd;
  logic           fe_push;
  logic           bs_held;
  logic           cmd_full;
  logic           cmd_valid;
  logic           cmd_pop;
  logic           res_room;
  logic           res_push0;
  logic           res_push1;
  logic [RW-1:0]  res0;
  logic [RW-1:0]  res1;
  logic [RW-1:0]  res_dout;
  logic           fin_taken;
  logic           status_only;
  logic           status_ok;
  logic           bare_last;
  logic           no_nl_err;

  assign full = cmd_full;

  bnls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .src_byte   (src_byte),
    .final_byte (final_byte),
    .q_full     (cmd_full),
    .q_cmd      (fe_cmd),
    .q_push     (fe_push),
    .held       (bs_held)
  );

  bnls_cmd_fifo #(
    .DEPTH (bnls_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fe_push),
    .din   (fe_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (be_cmd),
    .valid (cmd_valid)
  );

  bnls_back #(
    .LINE_BITS (LINE_BITS),
    .COL_BITS  (COL_BITS),
    .RW        (RW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (be_cmd),
    .room      (res_room),
    .cmd_pop   (cmd_pop),
    .res_push0 (res_push0),
    .res_push1 (res_push1),
    .res0      (res0),
    .res1      (res1)
  );

  bnls_res_fifo #(
    .W     (RW),
    .DEPTH (bnls_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push0 (res_push0),
    .push1 (res_push1),
    .d0    (res0),
    .d1    (res1),
    .room  (res_room),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign {has_char, char_out, is_newline, phys_line_out, column_out,
          logic_line_out, error_code, end_mark} = res_dout;

  assign fin_taken   = push && !full && final_byte;
  assign status_only = !empty && !has_char;
  assign status_ok   = end_mark && (error_code == bnls_pkg::ERR_SPLICE_EOF);
  assign bare_last   = !empty && has_char && end_mark && !is_newline;
  assign no_nl_err   = (error_code == bnls_pkg::ERR_NO_FINAL_NL);

  `BNLS_ASSERT_NEXT(a_final_clears_hold, fin_taken, !bs_held, "backslash held after final byte")
  `BNLS_ASSERT_NOW(a_status_only_eof, status_only, status_ok, "status-only result, no splice error")
  `BNLS_ASSERT_NOW(a_last_char_flagged, bare_last, no_nl_err, "missing final newline not flagged")

endmodule

`default_nettype wire
